// ===== rtl/spba_pkg.sv =====
// Package for the subpool bitmap counter allocator.
// Holds field widths, register indexes, status codes and the scan structs.
// No dependencies.
package spba_pkg;

    localparam int WORD_W          = 64;
    localparam int WORD_LW         = 6;

    localparam int MAX_COUNTERS_DEF = 4096;
    localparam int BANK_SIZE_DEF    = 256;

    localparam int POOL_W     = 13;
    localparam int BANKS_W    = 5;
    localparam int ESIZE_W    = 5;
    localparam int INDEX_W    = 12;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BANKS_FIRST       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BANKS_SECOND      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_SIZE_FIRST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_SIZE_SECOND = 3'd4;

    localparam logic [POOL_W-1:0]  POOL_SIZE_RST         = 13'd4096;
    localparam logic [BANKS_W-1:0] BANKS_FIRST_RST       = 5'd8;
    localparam logic [BANKS_W-1:0] BANKS_SECOND_RST      = 5'd8;
    localparam logic [ESIZE_W-1:0] ENTRY_SIZE_FIRST_RST  = 5'd1;
    localparam logic [ESIZE_W-1:0] ENTRY_SIZE_SECOND_RST = 5'd2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic               first;
        logic [WORD_LW-1:0] lo;
        logic               last;
        logic [WORD_LW-1:0] hi;
    } t_scan_cut;

    typedef struct packed {
        logic               found;
        logic [WORD_LW-1:0] bit_idx;
    } t_scan_hit;

endpackage

// ===== rtl/spba_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module spba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

// ===== rtl/spba_scan.sv =====
// Masked first-free search over one bitmap word.
// Depends on spba_pkg for the word width and the scan structs.
module spba_scan (
    input  logic [spba_pkg::WORD_W-1:0] i_word,
    input  spba_pkg::t_scan_cut         i_cut,
    output spba_pkg::t_scan_hit         o_hit
);
    import spba_pkg::*;

    logic [WORD_W-1:0] w_below;
    logic [WORD_W-1:0] w_keep;
    logic [WORD_W-1:0] w_used;

    always_comb begin
        w_below = i_cut.first ? ~({WORD_W{1'b1}} << i_cut.lo) : '0;
        w_keep  = i_cut.last ? ({WORD_W{1'b1}} >> (WORD_LW'(WORD_W - 1) - i_cut.hi))
                             : {WORD_W{1'b1}};
        w_used  = i_word | w_below | ~w_keep;
        o_hit.found   = ~&w_used;
        o_hit.bit_idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!w_used[i]) begin
                o_hit.bit_idx = WORD_LW'(i);
            end
        end
    end

endmodule

// ===== rtl/subpool_bitmap_counter_allocator.sv =====
// Subpool bitmap counter allocator: top level with FSM, layout and bitmap memory.
// Depends on spba_pkg, spba_ram and spba_scan.
//
// One request is taken at a time. The bitmap sits in a RAM of 64-bit words.
// A free clears the entry in the indexed word, and in the next one too when
// it crosses into it; an index beyond the pool fails at once. An allocate
// scans the subpool words in order up to the first free bit (at most the
// subpool length over 64; 32 at the default layout), one word per cycle
// through the single RAM read port, then sets the entry there and, when it
// crosses, in the next word. A full subpool fails after the scan, a free bit
// with no room for the entry when it is found, an empty one at once. After
// reset a clearing pass writes zero to every word, one per cycle, before the
// first request is taken; configuration writes are taken throughout. The
// result sits in an output register, so the next request is taken while it waits.
module subpool_bitmap_counter_allocator #(
    parameter int MAX_COUNTERS = spba_pkg::MAX_COUNTERS_DEF,
    parameter int BANK_SIZE    = spba_pkg::BANK_SIZE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [spba_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [spba_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_kind,
    input  logic                             i_subpool,
    input  logic [spba_pkg::INDEX_W-1:0]     i_free_index,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [spba_pkg::STATUS_W-1:0]    o_status,
    output logic [spba_pkg::INDEX_W-1:0]     o_alloc_index
);
    import spba_pkg::*;

    localparam int BW    = $clog2(BANK_SIZE + 1);
    localparam int PW    = $clog2(MAX_COUNTERS + 1);
    localparam int T1    = (BANKS_W + BW > PW) ? (BANKS_W + BW) : PW;
    localparam int LW    = ((T1 > POOL_W) ? T1 : POOL_W) + 1;
    localparam int WORDS = (MAX_COUNTERS + WORD_W - 1) / WORD_W;
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [WAW-1:0] LAST_W = WAW'(WORDS - 1);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_SETUP = 8'b0000_0100,
        S_SCAN  = 8'b0000_1000,
        S_LOAD  = 8'b0001_0000,
        S_WR0   = 8'b0010_0000,
        S_WR1   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [POOL_W-1:0]  r_pool_size;
    logic [BANKS_W-1:0] r_banks_first, r_banks_second;
    logic [ESIZE_W-1:0] r_es_first, r_es_second;

    logic [WAW-1:0]      r_clr_w, n_clr_w;
    logic                r_out_v, n_out_v;
    logic [STATUS_W-1:0] r_o_status, n_o_status;
    logic [INDEX_W-1:0]  r_o_index, n_o_index;

    logic                r_kind, n_kind;
    logic                r_sp, n_sp;
    logic [INDEX_W-1:0]  r_fidx, n_fidx;
    logic [ESIZE_W-1:0]  r_esize, n_esize;
    logic [LW-1:0]       r_end, n_end;
    logic [WORD_LW-1:0]  r_base_lo, n_base_lo;
    logic [WORD_LW-1:0]  r_hi, n_hi;
    logic [WAW-1:0]      r_first_w, n_first_w;
    logic [WAW-1:0]      r_last_w, n_last_w;
    logic [WAW-1:0]      r_issue_w, n_issue_w;
    logic                r_issue_end, n_issue_end;
    logic                r_eval_v, n_eval_v;
    logic [WAW-1:0]      r_eval_w, n_eval_w;
    logic [WORD_W-1:0]   r_word, n_word;
    logic [WAW-1:0]      r_wa, n_wa;
    logic [WORD_LW-1:0]  r_lo, n_lo;
    logic [INDEX_W-1:0]  r_pos_idx, n_pos_idx;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [INDEX_W-1:0]  r_index, n_index;

    logic [LW-1:0]       w_pool, w_base, w_len_raw, w_len, w_end, w_end_m1, w_pos;
    logic [ESIZE_W-1:0]  w_esize;
    logic [2*WORD_W-1:0] w_mask;
    logic [WORD_W-1:0]   w_mask_lo, w_mask_hi;
    logic                w_need1;
    logic [WAW-1:0]      w_wa1;

    logic                ram_we, ram_re;
    logic [WAW-1:0]      ram_waddr, ram_raddr;
    logic [WORD_W-1:0]   ram_wdata, ram_rdata;

    t_scan_cut scan_cut;
    t_scan_hit scan_hit;

    spba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    spba_scan u_scan (
        .i_word (ram_rdata),
        .i_cut  (scan_cut),
        .o_hit  (scan_hit)
    );

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_v;
    assign o_status      = r_o_status;
    assign o_alloc_index = r_o_index;

    always_comb begin
        w_pool    = (LW'(r_pool_size) > LW'(MAX_COUNTERS)) ? LW'(MAX_COUNTERS)
                                                          : LW'(r_pool_size);
        w_base    = r_sp ? LW'(r_banks_first) * LW'(BANK_SIZE) : '0;
        w_len_raw = (r_sp ? LW'(r_banks_second) : LW'(r_banks_first)) * LW'(BANK_SIZE);
        if (w_base >= w_pool) begin
            w_len = '0;
        end else if (w_len_raw > w_pool - w_base) begin
            w_len = w_pool - w_base;
        end else begin
            w_len = w_len_raw;
        end
        w_end    = w_base + w_len;
        w_end_m1 = w_end - LW'(1);
        w_esize  = r_sp ? r_es_second : r_es_first;
    end

    always_comb begin
        w_mask    = {{WORD_W{1'b0}}, ~({WORD_W{1'b1}} << r_esize)} << r_lo;
        w_mask_lo = w_mask[WORD_W-1:0];
        w_mask_hi = w_mask[2*WORD_W-1:WORD_W];
        w_wa1     = r_wa + WAW'(1);
        w_need1   = (|w_mask_hi) && (r_wa != LAST_W);
        w_pos     = (LW'(r_eval_w) << WORD_LW) | LW'(scan_hit.bit_idx);
        scan_cut.first = (r_eval_w == r_first_w);
        scan_cut.lo    = r_base_lo;
        scan_cut.last  = (r_eval_w == r_last_w);
        scan_cut.hi    = r_hi;
    end

    always_comb begin
        n_state     = r_state;
        n_clr_w     = r_clr_w;
        n_out_v     = r_out_v;
        n_o_status  = r_o_status;
        n_o_index   = r_o_index;
        n_kind      = r_kind;
        n_sp        = r_sp;
        n_fidx      = r_fidx;
        n_esize     = r_esize;
        n_end       = r_end;
        n_base_lo   = r_base_lo;
        n_hi        = r_hi;
        n_first_w   = r_first_w;
        n_last_w    = r_last_w;
        n_issue_w   = r_issue_w;
        n_issue_end = r_issue_end;
        n_eval_v    = r_eval_v;
        n_eval_w    = r_eval_w;
        n_word      = r_word;
        n_wa        = r_wa;
        n_lo        = r_lo;
        n_pos_idx   = r_pos_idx;
        n_status    = r_status;
        n_index     = r_index;
        ram_we      = 1'b0;
        ram_waddr   = r_wa;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = r_issue_w;

        if (r_out_v && !i_out_stall) begin
            n_out_v = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_w;
                ram_wdata = '0;
                if (r_clr_w == LAST_W) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_w = r_clr_w + WAW'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_kind  = i_kind;
                    n_sp    = i_subpool;
                    n_fidx  = i_free_index;
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_esize     = w_esize;
                n_end       = w_end;
                n_base_lo   = w_base[WORD_LW-1:0];
                n_hi        = w_end_m1[WORD_LW-1:0];
                n_first_w   = WAW'(w_base >> WORD_LW);
                n_last_w    = WAW'(w_end_m1 >> WORD_LW);
                n_issue_w   = WAW'(w_base >> WORD_LW);
                n_issue_end = 1'b0;
                n_eval_v    = 1'b0;
                n_lo        = r_fidx[WORD_LW-1:0];
                n_wa        = WAW'(r_fidx >> WORD_LW);
                if (r_kind == KIND_FREE) begin
                    if (LW'(r_fidx) >= w_pool) begin
                        n_status = ST_BAD_INDEX;
                        n_index  = '0;
                        n_state  = S_DONE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = WAW'(r_fidx >> WORD_LW);
                        n_state   = S_LOAD;
                    end
                end else if (w_len == '0) begin
                    n_status = ST_NO_SPACE;
                    n_index  = '0;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                ram_re   = !r_issue_end;
                n_eval_v = !r_issue_end;
                n_eval_w = r_issue_w;
                if (r_issue_w == r_last_w) begin
                    n_issue_end = 1'b1;
                end else begin
                    n_issue_w = r_issue_w + WAW'(1);
                end
                if (r_eval_v) begin
                    if (scan_hit.found) begin
                        if (w_pos + LW'(r_esize) > r_end) begin
                            n_status = ST_NO_SPACE;
                            n_index  = '0;
                            n_state  = S_DONE;
                        end else begin
                            n_word    = ram_rdata;
                            n_wa      = r_eval_w;
                            n_lo      = scan_hit.bit_idx;
                            n_pos_idx = w_pos[INDEX_W-1:0];
                            n_state   = S_WR0;
                        end
                    end else if (r_eval_w == r_last_w) begin
                        n_status = ST_NO_SPACE;
                        n_index  = '0;
                        n_state  = S_DONE;
                    end
                end
            end
            S_LOAD: begin
                n_word  = ram_rdata;
                n_state = S_WR0;
            end
            S_WR0: begin
                ram_we    = 1'b1;
                ram_waddr = r_wa;
                ram_wdata = (r_kind == KIND_FREE) ? (r_word & ~w_mask_lo)
                                                  : (r_word | w_mask_lo);
                if (w_need1) begin
                    ram_re    = 1'b1;
                    ram_raddr = w_wa1;
                    n_state   = S_WR1;
                end else begin
                    n_status = ST_OK;
                    n_index  = (r_kind == KIND_FREE) ? '0 : r_pos_idx;
                    n_state  = S_DONE;
                end
            end
            S_WR1: begin
                ram_we    = 1'b1;
                ram_waddr = w_wa1;
                ram_wdata = (r_kind == KIND_FREE) ? (ram_rdata & ~w_mask_hi)
                                                  : (ram_rdata | w_mask_hi);
                n_status  = ST_OK;
                n_index   = (r_kind == KIND_FREE) ? '0 : r_pos_idx;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_v || !i_out_stall) begin
                    n_out_v    = 1'b1;
                    n_o_status = r_status;
                    n_o_index  = r_index;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr_w        <= '0;
            r_out_v        <= 1'b0;
            r_pool_size    <= POOL_SIZE_RST;
            r_banks_first  <= BANKS_FIRST_RST;
            r_banks_second <= BANKS_SECOND_RST;
            r_es_first     <= ENTRY_SIZE_FIRST_RST;
            r_es_second    <= ENTRY_SIZE_SECOND_RST;
        end else begin
            r_state <= n_state;
            r_clr_w <= n_clr_w;
            r_out_v <= n_out_v;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_POOL_SIZE:         r_pool_size    <= i_cfg_data[POOL_W-1:0];
                    CFG_BANKS_FIRST:       r_banks_first  <= i_cfg_data[BANKS_W-1:0];
                    CFG_BANKS_SECOND:      r_banks_second <= i_cfg_data[BANKS_W-1:0];
                    CFG_ENTRY_SIZE_FIRST:  r_es_first     <= i_cfg_data[ESIZE_W-1:0];
                    CFG_ENTRY_SIZE_SECOND: r_es_second    <= i_cfg_data[ESIZE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_status  <= n_o_status;
        r_o_index   <= n_o_index;
        r_kind      <= n_kind;
        r_sp        <= n_sp;
        r_fidx      <= n_fidx;
        r_esize     <= n_esize;
        r_end       <= n_end;
        r_base_lo   <= n_base_lo;
        r_hi        <= n_hi;
        r_first_w   <= n_first_w;
        r_last_w    <= n_last_w;
        r_issue_w   <= n_issue_w;
        r_issue_end <= n_issue_end;
        r_eval_v    <= n_eval_v;
        r_eval_w    <= n_eval_w;
        r_word      <= n_word;
        r_wa        <= n_wa;
        r_lo        <= n_lo;
        r_pos_idx   <= n_pos_idx;
        r_status    <= n_status;
        r_index     <= n_index;
    end

endmodule
